/* hdl/bmrect_pkg.sv */
// Shared types, field widths and operation codes for the bitmap rectangle block.
// No dependencies; imported by bitmap_rectangle_set_clear_toggle_top.
package bmrect_pkg;

   // Field widths of one command beat and one result beat
   localparam int KIND_W  = 2;
   localparam int COORD_W = 10;
   localparam int COUNT_W = 21;

   // Grid storage word: 64 lights per word
   localparam int WORD_W      = 64;
   localparam int BIT_IDX_W   = 6;
   localparam int WORD_IDX_W  = COORD_W - BIT_IDX_W;
   localparam int PCNT_W      = 7;

   typedef logic [KIND_W-1:0]     kind_type;
   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [BIT_IDX_W-1:0]  bit_idx_type;
   typedef logic [WORD_IDX_W-1:0] word_idx_type;
   typedef logic [PCNT_W-1:0]     pcnt_type;

   // Operation codes; any other code inverts
   localparam kind_type KIND_ON     = 2'd0;
   localparam kind_type KIND_OFF    = 2'd1;
   localparam kind_type KIND_TOGGLE = 2'd2;

   localparam bit_idx_type BIT_IDX_LAST = '1;

   // Number of set bits in one grid word
   function automatic pcnt_type popcount_word(input word_type v);
      pcnt_type sum;
      sum = '0;
      for (int i = 0; i < WORD_W; i++) begin
         sum = sum + PCNT_W'(v[i]);
      end
      return sum;
   endfunction

endpackage

/* hdl/bitmap_rectangle_set_clear_toggle_top.sv */
// Bitmap rectangle set / clear / toggle engine with a running lit-light count.
// Depends on bmrect_pkg (widths, operation codes, word popcount).
//
//   channel   ports                              handshake
//   -------   --------------------------------   ------------------------------
//   command   req_kind, req_x_start, req_y_start  taken on start & !busy
//             req_x_end, req_y_end
//   result    rsp_lit_count                      rsp_valid strobe, one cycle
//
// A command spanning R rows and W 64-bit words per row does one read-modify-
// write per cycle through the single grid memory port pair, with busy high
// until the last write-back is counted; the result strobes as busy falls. An
// empty rectangle answers in the cycle after acceptance. After reset a
// clearing pass writes zero to every grid word, with busy high.
// The result side cannot stall; each result beat is shown once.
module bitmap_rectangle_set_clear_toggle_top
   import bmrect_pkg::*;
#(
   parameter int GRID_WIDTH  = 1024,
   parameter int GRID_HEIGHT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [COORD_W-1:0]  req_x_start,
   input  logic [COORD_W-1:0]  req_y_start,
   input  logic [COORD_W-1:0]  req_x_end,
   input  logic [COORD_W-1:0]  req_y_end,
   output logic                rsp_valid,
   output logic [COUNT_W-1:0]  rsp_lit_count
);

   localparam int ROW_WORDS  = (GRID_WIDTH + WORD_W - 1) / WORD_W;
   localparam int GRID_WORDS = ROW_WORDS * GRID_HEIGHT;
   localparam int ADDR_W     = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
   localparam int COORD_MAX  = (1 << COORD_W) - 1;
   localparam int X_LIM      = (GRID_WIDTH  - 1 < COORD_MAX) ? GRID_WIDTH  - 1 : COORD_MAX;
   localparam int Y_LIM      = (GRID_HEIGHT - 1 < COORD_MAX) ? GRID_HEIGHT - 1 : COORD_MAX;
   localparam coord_type X_LAST = COORD_W'(X_LIM);
   localparam coord_type Y_LAST = COORD_W'(Y_LIM);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ROW_WORDS);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(GRID_WORDS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Control registers
   state_type          state_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic               rsp_valid_ff;
   kind_type           kind_ff;
   coord_type          xs_ff;
   coord_type          xe_ff;
   coord_type          ye_ff;
   word_idx_type       wfirst_ff;
   word_idx_type       wlast_ff;
   word_idx_type       word_ff;
   coord_type          row_ff;
   logic [ADDR_W-1:0]  row_base_ff;

   // Pipeline registers: stage 1 has read data, stage 2 has popcounts
   logic               s1_valid_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   word_type           s1_mask_ff;
   word_type           rd_data_ff;
   logic               s2_valid_ff;
   pcnt_type           s2_old_ff;
   pcnt_type           s2_new_ff;
   count_type          lit_total_ff;

   // Grid memory
   word_type           grid_mem [GRID_WORDS];

   coord_type          xe_clip;
   coord_type          ye_clip;
   logic               rect_empty;
   logic               accept;
   logic               issue;
   logic               last_word;
   logic               last_row;
   logic [ADDR_W-1:0]  rd_addr;
   bit_idx_type        mask_lo;
   bit_idx_type        mask_hi;
   word_type           mask_in;
   word_type           new_word;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   word_type           wr_data;

   // Command decode: clip the end corner, detect an empty rectangle
   always_comb begin
      xe_clip    = (req_x_end > X_LAST) ? X_LAST : req_x_end;
      ye_clip    = (req_y_end > Y_LAST) ? Y_LAST : req_y_end;
      rect_empty = (req_x_start > xe_clip) || (req_y_start > ye_clip);
      accept     = start && (state_ff == ST_IDLE);
   end

   // Address walk and edge masks for the word being issued
   always_comb begin
      issue     = (state_ff == ST_RUN);
      last_word = (word_ff == wlast_ff);
      last_row  = (row_ff == ye_ff);
      rd_addr   = row_base_ff + ADDR_W'(word_ff);
      mask_lo   = (word_ff == wfirst_ff) ? xs_ff[BIT_IDX_W-1:0] : '0;
      mask_hi   = last_word ? xe_ff[BIT_IDX_W-1:0] : BIT_IDX_LAST;
      mask_in   = ({WORD_W{1'b1}} >> (BIT_IDX_LAST - mask_hi)) &
                  ({WORD_W{1'b1}} << mask_lo);
   end

   // Raster op on the word that came back from memory
   always_comb begin
      priority if (kind_ff == KIND_ON) begin
         new_word = rd_data_ff | s1_mask_ff;
      end else if (kind_ff == KIND_OFF) begin
         new_word = rd_data_ff & ~s1_mask_ff;
      end else begin
         new_word = rd_data_ff ^ s1_mask_ff;
      end
   end

   // Write port: clearing pass or write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff;
         wr_addr = s1_addr_ff;
         wr_data = new_word;
      end
   end

   // Grid memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // Sequencer: clearing pass, command capture, rectangle walk, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (rect_empty) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (last_word && last_row) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!s1_valid_ff && !s2_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Command payload and walk position
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         xs_ff       <= req_x_start;
         xe_ff       <= xe_clip;
         ye_ff       <= ye_clip;
         wfirst_ff   <= req_x_start[COORD_W-1:BIT_IDX_W];
         wlast_ff    <= xe_clip[COORD_W-1:BIT_IDX_W];
         word_ff     <= req_x_start[COORD_W-1:BIT_IDX_W];
         row_ff      <= req_y_start;
         row_base_ff <= ADDR_W'(ADDR_W'(req_y_start) * ROW_STEP);
      end else if (issue) begin
         if (last_word) begin
            word_ff     <= wfirst_ff;
            row_ff      <= row_ff + 1'b1;
            row_base_ff <= row_base_ff + ROW_STEP;
         end else begin
            word_ff <= word_ff + 1'b1;
         end
      end
   end

   // Read-modify-write pipeline and running count
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         lit_total_ff <= '0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            lit_total_ff <= lit_total_ff - COUNT_W'(s2_old_ff) + COUNT_W'(s2_new_ff);
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_addr_ff <= rd_addr;
      s1_mask_ff <= mask_in;
      s2_old_ff  <= popcount_word(rd_data_ff);
      s2_new_ff  <= popcount_word(new_word);
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lit_count = lit_total_ff;

endmodule

/* verif/bitmap_rectangle_set_clear_toggle_top_tb.sv */
// Testbench for bitmap_rectangle_set_clear_toggle_top: rectangle set/clear/toggle commands
// checked against a bitmap predictor of the lit-light count. Depends on bmrect_pkg and the RTL.
// Directed table first, then random rectangles issued in bursts with random gaps.
module bitmap_rectangle_set_clear_toggle_top_tb
   import bmrect_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_COLS    = 1024;
   localparam int GRID_ROWS    = 1024;
   localparam int ROW_WORDS    = (GRID_COLS + 63) / 64;
   localparam int GRID_WORDS   = ROW_WORDS * GRID_ROWS;
   localparam int COORD_MAX    = (1 << COORD_W) - 1;
   localparam int RANDOM_CMDS  = 81;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;
   // slowest correct run: clearing pass plus ~100 full-grid commands with gaps, times ~4
   localparam longint CYCLE_LIMIT = 8_000_000;

   // the code that no named operation uses; the block treats it as toggle
   localparam kind_type KIND_SPARE = 2'd3;

   typedef struct {
      kind_type  kind;
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      bit        known;
      count_type lit;
   } rect_cmd_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   kind_type  req_kind;
   coord_type req_x_start;
   coord_type req_y_start;
   coord_type req_x_end;
   coord_type req_y_end;
   logic      rsp_valid;
   count_type rsp_lit_count;

   // predictor state: the light bitmap and its running count
   bit [WORD_W-1:0] lamp_words [GRID_WORDS];
   int unsigned     lamps_lit;

   count_type pending_counts [$];
   count_type want_count;
   int        mismatches;
   int        burst_left;
   longint    cycle_count;

   // directed commands; expected count typed in only where obvious
   rect_cmd_type directed_cmds [0:18] = '{
      '{KIND_ON,     10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd1048576},
      '{KIND_OFF,    10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd0},
      '{KIND_TOGGLE, 10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 21'd1},
      '{KIND_TOGGLE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 21'd2},
      '{KIND_SPARE,  10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 21'd1},
      '{KIND_ON,     10'd5,    10'd3,    10'd2,    10'd9,    1'b1, 21'd1},
      '{KIND_ON,     10'd3,    10'd9,    10'd7,    10'd2,    1'b1, 21'd1},
      '{KIND_ON,     10'd1023, 10'd1023, 10'd0,    10'd0,    1'b1, 21'd1},
      '{KIND_ON,     10'd63,   10'd0,    10'd64,   10'd0,    1'b1, 21'd3},
      '{KIND_ON,     10'd0,    10'd1,    10'd63,   10'd1,    1'b0, 21'd0},
      '{KIND_TOGGLE, 10'd1,    10'd1,    10'd62,   10'd1,    1'b0, 21'd0},
      '{KIND_OFF,    10'd960,  10'd1000, 10'd1023, 10'd1023, 1'b0, 21'd0},
      '{KIND_TOGGLE, 10'd0,    10'd0,    10'd1023, 10'd0,    1'b0, 21'd0},
      '{KIND_TOGGLE, 10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0, 21'd0},
      '{KIND_OFF,    10'd512,  10'd512,  10'd511,  10'd511,  1'b0, 21'd0},
      '{KIND_ON,     10'd1023, 10'd0,    10'd1023, 10'd1023, 1'b0, 21'd0},
      '{KIND_TOGGLE, 10'd100,  10'd200,  10'd300,  10'd250,  1'b0, 21'd0},
      '{KIND_SPARE,  10'd0,    10'd0,    10'd1023, 10'd1023, 1'b0, 21'd0},
      '{KIND_OFF,    10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd0}
   };

   bitmap_rectangle_set_clear_toggle_top #(
      .GRID_WIDTH  (GRID_COLS),
      .GRID_HEIGHT (GRID_ROWS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_x_start   (req_x_start),
      .req_y_start   (req_y_start),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .rsp_valid     (rsp_valid),
      .rsp_lit_count (rsp_lit_count)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one raster op to the bitmap and return the new lit count
   function automatic count_type apply_rect_op(input rect_cmd_type c);
      int unsigned     col_last, row_last, word_first, word_last, lo, hi, idx;
      bit [WORD_W-1:0] mask, old_word, new_word;
      col_last = (c.xe > GRID_COLS - 1) ? GRID_COLS - 1 : c.xe;
      row_last = (c.ye > GRID_ROWS - 1) ? GRID_ROWS - 1 : c.ye;
      if (c.xs <= col_last && c.ys <= row_last) begin
         word_first = c.xs / 64;
         word_last  = col_last / 64;
         for (int unsigned r = c.ys; r <= row_last; r++) begin
            for (int unsigned w = word_first; w <= word_last; w++) begin
               lo   = (w == word_first) ? c.xs % 64 : 0;
               hi   = (w == word_last) ? col_last % 64 : 63;
               mask = ({WORD_W{1'b1}} >> (63 - hi)) & ({WORD_W{1'b1}} << lo);
               idx  = r * ROW_WORDS + w;
               old_word = lamp_words[idx];
               case (c.kind)
                  KIND_ON:  new_word = old_word | mask;
                  KIND_OFF: new_word = old_word & ~mask;
                  default:  new_word = old_word ^ mask;
               endcase
               lamp_words[idx] = new_word;
               lamps_lit = lamps_lit - $countones(old_word) + $countones(new_word);
            end
         end
      end
      return count_type'(lamps_lit);
   endfunction

   // random rectangle; mostly small ones, some wide, some empty, a few near full grid
   function automatic rect_cmd_type random_rect();
      rect_cmd_type c;
      int unsigned  shape, pick, a, b, e;
      shape = $urandom_range(0, 99);
      pick  = $urandom_range(0, 9);
      c.kind  = (pick < 3) ? KIND_ON : (pick < 6) ? KIND_OFF :
                (pick < 9) ? KIND_TOGGLE : KIND_SPARE;
      c.known = 1'b0;
      c.lit   = '0;
      if (shape < 60) begin
         // small; half of them crowd one corner so they overlap
         if (shape < 30) begin
            c.xs = coord_type'($urandom_range(0, 255));
            c.ys = coord_type'($urandom_range(0, 31));
         end else begin
            c.xs = coord_type'($urandom_range(0, COORD_MAX));
            c.ys = coord_type'($urandom_range(0, COORD_MAX));
         end
         e = c.xs + $urandom_range(0, 200);
         c.xe = coord_type'((e > COORD_MAX) ? COORD_MAX : e);
         e = c.ys + $urandom_range(0, 40);
         c.ye = coord_type'((e > COORD_MAX) ? COORD_MAX : e);
      end else if (shape < 80) begin
         // any column span, up to 128 rows
         a = $urandom_range(0, COORD_MAX);
         b = $urandom_range(0, COORD_MAX);
         c.xs = coord_type'((a < b) ? a : b);
         c.xe = coord_type'((a < b) ? b : a);
         c.ys = coord_type'($urandom_range(0, COORD_MAX));
         e = c.ys + $urandom_range(0, 127);
         c.ye = coord_type'((e > COORD_MAX) ? COORD_MAX : e);
      end else if (shape < 97) begin
         // start past end, in x or in y
         a = $urandom_range(1, COORD_MAX);
         b = $urandom_range(0, a - 1);
         if (shape[0]) begin
            c.xs = coord_type'(a);
            c.xe = coord_type'(b);
            c.ys = coord_type'($urandom_range(0, COORD_MAX));
            c.ye = coord_type'($urandom_range(0, COORD_MAX));
         end else begin
            c.ys = coord_type'(a);
            c.ye = coord_type'(b);
            c.xs = coord_type'($urandom_range(0, COORD_MAX));
            c.xe = coord_type'($urandom_range(0, COORD_MAX));
         end
      end else begin
         c.xs = coord_type'($urandom_range(0, 63));
         c.ys = coord_type'($urandom_range(0, 15));
         c.xe = coord_type'($urandom_range(960, COORD_MAX));
         c.ye = coord_type'($urandom_range(1008, COORD_MAX));
      end
      return c;
   endfunction

   task automatic log_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // issue one command beat; between bursts of random length the sender idles for a random gap, possibly none
   task automatic issue_rect(input rect_cmd_type c);
      int unsigned gap;
      count_type   predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      start       <= 1'b1;
      req_kind    <= c.kind;
      req_x_start <= c.xs;
      req_y_start <= c.ys;
      req_x_end   <= c.xe;
      req_y_end   <= c.ye;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // beat taken at this edge
      predicted = apply_rect_op(c);
      if (c.known) predicted = c.lit;
      pending_counts = {pending_counts, predicted};
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_counts.size() == 0) begin
            log_mismatch($sformatf("result beat with none expected, lit_count %0d",
                                   rsp_lit_count));
         end else begin
            want_count = pending_counts.pop_front();
            if (rsp_lit_count !== want_count)
               log_mismatch($sformatf("lit_count expected %0d actual %0d",
                                      want_count, rsp_lit_count));
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_kind    = KIND_ON;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end   = '0;
      req_y_end   = '0;
      lamps_lit   = 0;
      mismatches  = 0;
      burst_left  = 0;
      cycle_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_cmds[i]) issue_rect(directed_cmds[i]);
      repeat (RANDOM_CMDS) issue_rect(random_rect());
      @(negedge clock);
      start <= 1'b0;

      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
